@@ rtl/meu_pkg.sv @@
// Shared types and constants for the multi-turn encoder unwrap block.
`default_nettype none

package meu_pkg;

  localparam int RAW_W      = 18;
  localparam int DELTA_W    = 19;
  localparam int TOTAL_W    = 64;
  localparam int PHASE_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Encoder range: 25 * 2^13 counts per revolution of the raw reading.
  localparam logic [31:0]      RAW_RANGE_32 = 32'd204800;
  localparam logic [RAW_W-1:0] RAW_RANGE    = 18'd204800;
  localparam int               FOLD_LOW_W   = 13;
  // floor(x / 25) == (x * FOLD_MULT) >> FOLD_SHIFT for every 19-bit x.
  localparam logic [19:0]      FOLD_MULT    = 20'd671089;
  localparam int               FOLD_SHIFT   = 24;

  localparam logic signed [DELTA_W-1:0] RANGE_S    = 19'sd204800;
  localparam logic signed [DELTA_W-1:0] HALF_S     = 19'sd102400;
  localparam logic signed [DELTA_W-1:0] ABNORMAL_S = 19'sd40960;

  // Steering turn: 7 * 2^11 pulses.
  localparam int PHASE_LOW_W = 11;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_HOME   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_OFFSET   = 3'd0,
    CFG_PHASE_ANCHOR  = 3'd1,
    CFG_SAVED_TOTAL   = 3'd2,
    CFG_SAVED_RAW     = 3'd3,
    CFG_RESTORE_ARMED = 3'd4
  } meu_cfg_idx_t;

  typedef struct packed {
    logic                      opcode;
    logic [31:0]               raw_reading;
    logic signed [TOTAL_W-1:0] home_total;
  } meu_in_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] unwrapped_total;
    logic [PHASE_W-1:0]        steer_phase;
    logic [RAW_W-1:0]          calibrated_raw;
    logic                      restore_ok;
    logic                      degraded;
    logic                      range_warning;
  } meu_out_t;

  // Folded sample on its way into the tracking stage.
  typedef struct packed {
    logic                      opcode;
    logic [RAW_W-1:0]          folded;
    logic                      warn;
    logic signed [TOTAL_W-1:0] home_total;
  } meu_fold_t;

  // Tracking stage result.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [RAW_W-1:0]   folded;
    logic               warn;
    logic               restore_ok;
    logic               degraded;
  } meu_track_t;

endpackage

`default_nettype wire

@@ rtl/meu_fold.sv @@
// Folds a 32-bit raw encoder reading into the encoder range.
`default_nettype none

module meu_fold
  import meu_pkg::*;
(
  input  wire logic [31:0]      raw,
  output logic      [RAW_W-1:0] folded,
  output logic                  warn
);

  logic [18:0] hi;
  logic [38:0] prod;
  logic [14:0] quo;
  logic [18:0] quo25;
  logic [18:0] rem;

  // Low 13 bits pass through; the upper part is reduced mod 25.
  assign hi    = raw[31:FOLD_LOW_W];
  assign prod  = {20'd0, hi} * {19'd0, FOLD_MULT};
  assign quo   = prod[38:FOLD_SHIFT];
  assign quo25 = {quo, 4'd0} + {1'b0, quo, 3'd0} + {4'd0, quo};
  assign rem   = hi - quo25;

  assign folded = {rem[4:0], raw[FOLD_LOW_W-1:0]};
  assign warn   = (raw >= RAW_RANGE_32);

endmodule

`default_nettype wire

@@ rtl/meu_track.sv @@
// Unwrap state: shortest-path delta, running total, restore and home handling.
`default_nettype none

module meu_track
  import meu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire meu_fold_t           fold_in,
  input  wire logic [TOTAL_W-1:0]  stored_total,
  input  wire logic [RAW_W-1:0]    stored_raw,
  input  wire logic                restore_armed,
  input  wire logic                rearm,
  output meu_track_t               track_out
);

  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [RAW_W-1:0]   prev_raw_r, prev_raw_nxt;
  logic               baseline_r, baseline_nxt;
  logic               consumed_r, consumed_nxt;
  logic               rok_r, rok_nxt;
  logic               deg_r, deg_nxt;
  meu_track_t         track_r, track_nxt;

  logic                      restore;
  logic [RAW_W-1:0]          saved_fold;
  logic [RAW_W-1:0]          ref_raw;
  logic signed [DELTA_W-1:0] d_raw;
  logic signed [DELTA_W-1:0] delta;
  logic                      abnormal;
  logic [TOTAL_W-1:0]        base;
  logic [TOTAL_W-1:0]        sum;

  always_comb begin
    saved_fold = (stored_raw >= RAW_RANGE) ? (stored_raw - RAW_RANGE) : stored_raw;
    restore    = !baseline_r && restore_armed && !consumed_r;
    ref_raw    = baseline_r ? prev_raw_r : saved_fold;
    d_raw      = $signed({1'b0, fold_in.folded}) - $signed({1'b0, ref_raw});
    if (d_raw > HALF_S) begin
      delta = d_raw - RANGE_S;
    end else if (d_raw < -HALF_S) begin
      delta = d_raw + RANGE_S;
    end else begin
      delta = d_raw;
    end
    abnormal = (delta > ABNORMAL_S) || (delta < -ABNORMAL_S);
    base     = baseline_r ? total_r : stored_total;
    sum      = base + {{(TOTAL_W-DELTA_W){delta[DELTA_W-1]}}, delta};
  end

  always_comb begin
    total_nxt    = total_r;
    prev_raw_nxt = prev_raw_r;
    baseline_nxt = baseline_r;
    consumed_nxt = consumed_r;
    rok_nxt      = rok_r;
    deg_nxt      = deg_r;
    if (take) begin
      if (fold_in.opcode == OP_HOME) begin
        total_nxt    = fold_in.home_total;
        baseline_nxt = 1'b1;
        rok_nxt      = 1'b1;
        deg_nxt      = 1'b0;
        consumed_nxt = 1'b1;
      end else begin
        prev_raw_nxt = fold_in.folded;
        baseline_nxt = 1'b1;
        if (baseline_r || restore) begin
          total_nxt = sum;
        end else begin
          total_nxt = {{(TOTAL_W-RAW_W){1'b0}}, fold_in.folded};
        end
        if (restore) begin
          deg_nxt      = abnormal;
          rok_nxt      = !abnormal;
          consumed_nxt = 1'b1;
        end else if (!baseline_r) begin
          // cold start
          deg_nxt = 1'b1;
          rok_nxt = 1'b0;
        end
      end
    end else if (rearm) begin
      consumed_nxt = 1'b0;
    end
  end

  always_comb begin
    track_nxt.total      = total_nxt;
    track_nxt.restore_ok = rok_nxt;
    track_nxt.degraded   = deg_nxt;
    if (fold_in.opcode == OP_HOME) begin
      track_nxt.folded = prev_raw_r;
      track_nxt.warn   = 1'b0;
    end else begin
      track_nxt.folded = fold_in.folded;
      track_nxt.warn   = fold_in.warn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      prev_raw_r <= '0;
      baseline_r <= 1'b0;
      consumed_r <= 1'b0;
      rok_r      <= 1'b0;
      deg_r      <= 1'b0;
    end else begin
      total_r    <= total_nxt;
      prev_raw_r <= prev_raw_nxt;
      baseline_r <= baseline_nxt;
      consumed_r <= consumed_nxt;
      rok_r      <= rok_nxt;
      deg_r      <= deg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      track_r <= track_nxt;
    end
  end

  assign track_out = track_r;

endmodule

`default_nettype wire

@@ rtl/meu_phase.sv @@
// Positive modulo of a signed 64-bit difference by the steering turn (7 * 2^11).
`default_nettype none

module meu_phase
  import meu_pkg::*;
(
  input  wire logic [TOTAL_W-1:0] diff,
  output logic      [PHASE_W-1:0] phase
);

  logic [52:0] hi;
  logic [14:0] s1;
  logic [5:0]  s2;
  logic [5:0]  t1;
  logic [5:0]  t2;
  logic [5:0]  t3;

  // hi is floor(diff / 2^11); 2^12 and 2^3 are 1 mod 7, the sign bit is 5 mod 7.
  assign hi = diff[TOTAL_W-1:PHASE_LOW_W];

  always_comb begin
    s1 = {3'd0, hi[11:0]} + {3'd0, hi[23:12]} + {3'd0, hi[35:24]}
       + {3'd0, hi[47:36]} + {12'd0, hi[50:48]} + {14'd0, hi[51]}
       + (hi[52] ? 15'd5 : 15'd0);
    s2 = {3'd0, s1[2:0]} + {3'd0, s1[5:3]} + {3'd0, s1[8:6]}
       + {3'd0, s1[11:9]} + {3'd0, s1[14:12]};
    t1 = (s2 >= 6'd28) ? (s2 - 6'd28) : s2;
    t2 = (t1 >= 6'd14) ? (t1 - 6'd14) : t1;
    t3 = (t2 >= 6'd7)  ? (t2 - 6'd7)  : t2;
  end

  assign phase = {t3[2:0], diff[PHASE_LOW_W-1:0]};

endmodule

`default_nettype wire

@@ rtl/multi_turn_encoder_unwrap.sv @@
// Multi-turn encoder unwrap: top level with config registers and pipeline.
//
//   channel  ports                          direction  beat
//   input    in_valid/in_stall/in_data      in         opcode, raw reading, home total
//   result   out_valid/out_stall/out_data   out        total, phase, raw, flags
//   config   cfg_we/cfg_index/cfg_data      in         one register write per cycle
//
// One beat per cycle sustained while out_stall stays low; an accepted input beat
// passes input reg, fold, tracking, anchor subtract and phase/output reg to out_valid.
// The tracking stage's 64-bit running-total add is the only feedback loop.
// Reset (rst_n low at a clock edge) clears all valids, state and config.
// out_stall holds the output register; earlier stages fill bubbles, and
// in_stall rises only when every stage holds a beat.
`default_nettype none

module multi_turn_encoder_unwrap
  import meu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire meu_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output meu_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] diff;
    logic [RAW_W-1:0]   cal;
    logic               warn;
    logic               restore_ok;
    logic               degraded;
  } meu_calc_t;

  logic [RAW_W-1:0]   zero_off_r;
  logic [TOTAL_W-1:0] anchor_r;
  logic [TOTAL_W-1:0] stored_total_r;
  logic [RAW_W-1:0]   stored_raw_r;
  logic               armed_r;
  logic               rearm;

  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic v0_nxt, v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic adv0, adv1, adv2, adv3, adv4;

  meu_in_t    in_r;
  meu_fold_t  fold_r, fold_nxt;
  meu_track_t track;
  meu_calc_t  calc_r, calc_nxt;
  meu_out_t   out_r, out_nxt;

  logic [RAW_W-1:0]   off_mod;
  logic [RAW_W-1:0]   cal_diff;
  logic [PHASE_W-1:0] phase;

  // ---------------- configuration ----------------
  assign rearm = cfg_we && (cfg_index == CFG_RESTORE_ARMED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_off_r     <= '0;
      anchor_r       <= '0;
      stored_total_r <= '0;
      stored_raw_r   <= '0;
      armed_r        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZERO_OFFSET:   zero_off_r     <= cfg_data[RAW_W-1:0];
        CFG_PHASE_ANCHOR:  anchor_r       <= cfg_data;
        CFG_SAVED_TOTAL:   stored_total_r <= cfg_data;
        CFG_SAVED_RAW:     stored_raw_r   <= cfg_data[RAW_W-1:0];
        CFG_RESTORE_ARMED: armed_r        <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  assign adv4 = !v4_r || !out_stall;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign adv0 = !v0_r || adv1;

  assign in_stall = !adv0;

  always_comb begin
    v0_nxt = adv0 ? in_valid : v0_r;
    v1_nxt = adv1 ? v0_r     : v1_r;
    v2_nxt = adv2 ? v1_r     : v2_r;
    v3_nxt = adv3 ? v2_r     : v3_r;
    v4_nxt = adv4 ? v3_r     : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // ---------------- stage 0: input register ----------------
  always_ff @(posedge clk) begin
    if (adv0) begin
      in_r <= in_data;
    end
  end

  // ---------------- stage 1: fold ----------------
  meu_fold u_fold (
    .raw    (in_r.raw_reading),
    .folded (fold_nxt.folded),
    .warn   (fold_nxt.warn)
  );

  assign fold_nxt.opcode     = in_r.opcode;
  assign fold_nxt.home_total = in_r.home_total;

  always_ff @(posedge clk) begin
    if (adv1) begin
      fold_r <= fold_nxt;
    end
  end

  // ---------------- stage 2: tracking ----------------
  meu_track u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (adv2 && v1_r),
    .fold_in       (fold_r),
    .stored_total  (stored_total_r),
    .stored_raw    (stored_raw_r),
    .restore_armed (armed_r),
    .rearm         (rearm),
    .track_out     (track)
  );

  // ---------------- stage 3: anchor difference, calibrated raw ----------------
  always_comb begin
    off_mod  = (zero_off_r >= RAW_RANGE) ? (zero_off_r - RAW_RANGE) : zero_off_r;
    cal_diff = track.folded - off_mod;
    calc_nxt.total      = track.total;
    calc_nxt.diff       = track.total - anchor_r;
    calc_nxt.cal        = (track.folded < off_mod) ? (cal_diff + RAW_RANGE) : cal_diff;
    calc_nxt.warn       = track.warn;
    calc_nxt.restore_ok = track.restore_ok;
    calc_nxt.degraded   = track.degraded;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      calc_r <= calc_nxt;
    end
  end

  // ---------------- stage 4: phase, output register ----------------
  meu_phase u_phase (
    .diff  (calc_r.diff),
    .phase (phase)
  );

  always_comb begin
    out_nxt.unwrapped_total = calc_r.total;
    out_nxt.steer_phase     = phase;
    out_nxt.calibrated_raw  = calc_r.cal;
    out_nxt.restore_ok      = calc_r.restore_ok;
    out_nxt.degraded        = calc_r.degraded;
    out_nxt.range_warning   = calc_r.warn;
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ rtl/meu_chk.sv @@
// Port-level checker for the encoder unwrap block, bound to the top level.
`default_nettype none

module meu_chk
  import meu_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire meu_out_t out_data
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A free output side never back-pressures the input.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.steer_phase < 14'd14336))
    else $error("steering phase out of range");

  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.calibrated_raw < RAW_RANGE))
    else $error("calibrated raw out of range");

  // Restored/homed and degraded never show together.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.restore_ok && out_data.degraded))
    else $error("restore_ok and degraded both set");

endmodule

bind multi_turn_encoder_unwrap meu_chk u_meu_chk (.*);

`default_nettype wire
